>>> hdl/tcw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Item kinds, character codes, reset colors and the command and status
// bundles that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry defaults.
  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  // Stream and configuration port widths.
  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FG = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG = 1'd1;

  // Register reset values and the blank cell written by the reset clearing pass.
  localparam logic [3:0]  RESET_FG    = 4'd10;
  localparam logic [3:0]  RESET_BG    = 4'd0;
  localparam logic [7:0]  BLANK_CHAR  = 8'h20;
  localparam logic [15:0] RESET_BLANK = {RESET_BG, RESET_FG, BLANK_CHAR};

  // Control characters.
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam int         TAB_STEP = 4;

  typedef enum logic [1:0] {
    KIND_PUT    = 2'd0,
    KIND_SETCUR = 2'd1,
    KIND_CLEAR  = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  // Controller to datapath.
  typedef struct packed {
    logic capture;      // latch the accepted input word
    logic put;          // put character: write cell, move cursor
    logic setcur;       // load saturated coordinates into the cursor
    logic clear;        // home the cursor for a clear screen
    logic rd;           // issue the cell read
    logic rd_latch;     // capture the read data
    logic sweep_start;  // start a pass over the whole screen
    logic sweep_copy;   // pass moves rows up (scroll) rather than filling
    logic load_out;     // load the output register
  } tcw_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    kind_t kind;
    logic  will_scroll;
    logic  sweep_busy;
    logic  out_free;
  } tcw_sts_t;

endpackage
`default_nettype wire

>>> hdl/text_console_writer_core.sv
`default_nettype none
// Steps: put character, set cursor and clear go through accept, execute and
//   result step; read cell adds an address and a wait step between execute
//   and result, and a scroll or clear adds a sweep step that lasts until the
//   pass ends. A new word is taken only from the idle state, and a stalled
//   output keeps the controller in the result step, so no new word is taken.
// Reset: synchronous, active low. A clearing pass then fills the screen with
//   0x0A20, and in_tready stays low until the pass ends.
// ----------------------------------------------------------------------------
// text_console_writer_core: text screen writer with cursor
// A screen of character-plus-color cells in block RAM. Put character handles
// newline, carriage return and tab, writes other bytes at the cursor, wraps
// at the right edge and scrolls at the bottom. Set cursor, clear screen and
// read cell complete the operations.
// ----------------------------------------------------------------------------
module text_console_writer_core import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // Configuration: index 0 foreground color, index 1 background color.
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // Input words.
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // in_tdata: char_code [7:0], col [14:8], row [19:15], zero [23:20]
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: kind [1:0]
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,
  // Result words.
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // out_tdata: cell_data [15:0], cursor_col [22:16], cursor_row [27:23],
  //            scrolled [28], zero [31:29]
  output logic      [OUT_TDATA_W-1:0] out_tdata
);

  // The controller only sequences; every register that holds screen, cursor
  // or result state lives in the datapath.
  tcw_cmd_t cmd;
  tcw_sts_t sts;

  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  // The datapath keeps a single screen RAM port pair: a scroll reads row r+1
  // and writes row r in the next cycle, so the move runs at one cell per cycle.
  tcw_dp #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule
`default_nettype wire

>>> hdl/tcw_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 2000,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> hdl/tcw_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_ctrl: sequencing state machine of the text console writer
// Accepts one word at a time, steps the datapath through it and hands
// the result to the output register.
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  output tcw_cmd_t      cmd_o,
  input  wire tcw_sts_t sts_i
);

  typedef enum logic [6:0] {
    S_INIT  = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_EXEC  = 7'b0000100,
    S_RWAIT = 7'b0001000,
    S_SWEEP = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_RADDR = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    case (state_r)
      S_INIT: begin
        // The datapath runs the reset clearing pass on its own.
        if (!sts_i.sweep_busy) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_o.capture = 1'b1;
          state_nxt     = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts_i.kind)
          KIND_PUT: begin
            cmd_o.put = 1'b1;
            if (sts_i.will_scroll) begin
              cmd_o.sweep_start = 1'b1;
              cmd_o.sweep_copy  = 1'b1;
              state_nxt         = S_SWEEP;
            end else begin
              state_nxt = S_DONE;
            end
          end
          KIND_SETCUR: begin
            cmd_o.setcur = 1'b1;
            state_nxt    = S_DONE;
          end
          KIND_CLEAR: begin
            cmd_o.clear       = 1'b1;
            cmd_o.sweep_start = 1'b1;
            state_nxt         = S_SWEEP;
          end
          KIND_READ: begin
            state_nxt = S_RADDR;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_RADDR: begin
        cmd_o.rd  = 1'b1;
        state_nxt = S_RWAIT;
      end
      S_RWAIT: begin
        cmd_o.rd_latch = 1'b1;
        state_nxt      = S_DONE;
      end
      S_SWEEP: begin
        if (!sts_i.sweep_busy) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_INIT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

>>> hdl/tcw_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcw_dp: datapath of the text console writer
// Color registers, cursor, input and output registers, the screen RAM and
// the sweep unit that clears the screen or moves every row up by one.
// ----------------------------------------------------------------------------
module tcw_dp import tcw_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,
  input  wire tcw_cmd_t               cmd_i,
  output tcw_sts_t                    sts_o
);

  localparam int DEPTH = COLUMNS * ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);

  localparam logic [AW-1:0] COLS_A    = AW'(COLUMNS);
  localparam logic [AW-1:0] COPY_LAST = AW'(DEPTH - COLUMNS);
  localparam logic [AW-1:0] LAST_A    = AW'(DEPTH - 1);
  localparam logic [CW:0]   COL_LIM   = (CW+1)'(COLUMNS);
  localparam logic [CW:0]   TAB_A     = (CW+1)'(TAB_STEP);
  localparam logic [CW:0]   TAB_MASK  = ~((CW+1)'(TAB_STEP - 1));
  localparam logic [RW-1:0] ROW_LAST  = RW'(ROWS - 1);
  localparam logic [CW-1:0] COL_LAST  = CW'(COLUMNS - 1);
  localparam logic [7:0]    IN_COL_LIM = 8'(COLUMNS);
  localparam logic [6:0]    IN_ROW_LIM = 7'(ROWS);

  // Color registers.
  logic [3:0] fg_r, bg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= RESET_FG;
      bg_r <= RESET_BG;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FG:  fg_r <= cfg_data;
        REG_BG:  bg_r <= cfg_data;
        default: ;
      endcase
    end
  end
  wire logic [7:0]  color = {bg_r, fg_r};
  wire logic [15:0] blank = {color, BLANK_CHAR};

  // Captured input word, coordinates saturated to the screen.
  kind_t         kind_r;
  logic [7:0]    char_r;
  logic [CW-1:0] sat_col_r;
  logic [RW-1:0] sat_row_r;
  wire logic [6:0] in_col = in_tdata[14:8];
  wire logic [4:0] in_row = in_tdata[19:15];

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      kind_r    <= kind_t'(in_tuser);
      char_r    <= in_tdata[7:0];
      sat_col_r <= ({1'b0, in_col} >= IN_COL_LIM) ? COL_LAST : CW'(in_col);
      sat_row_r <= ({2'b0, in_row} >= IN_ROW_LIM) ? ROW_LAST : RW'(in_row);
    end
  end

  // Put-character cursor arithmetic.
  logic [CW-1:0] cur_col_r, cur_col_nxt;
  logic [RW-1:0] cur_row_r, cur_row_nxt;
  logic [CW:0]   pc_col;
  logic          pc_rinc;
  logic          pc_write;
  logic          will_scroll;

  always_comb begin
    pc_rinc  = 1'b0;
    pc_write = 1'b0;
    case (char_r)
      CH_LF: begin
        pc_col  = '0;
        pc_rinc = 1'b1;
      end
      CH_CR:  pc_col = '0;
      CH_TAB: pc_col = ({1'b0, cur_col_r} + TAB_A) & TAB_MASK;
      default: begin
        pc_col   = {1'b0, cur_col_r} + (CW+1)'(1);
        pc_write = 1'b1;
      end
    endcase
    if (pc_col >= COL_LIM) begin
      pc_col  = '0;
      pc_rinc = 1'b1;
    end
    will_scroll = pc_rinc && (cur_row_r == ROW_LAST);
  end

  always_comb begin
    cur_col_nxt = cur_col_r;
    cur_row_nxt = cur_row_r;
    if (cmd_i.put) begin
      cur_col_nxt = pc_col[CW-1:0];
      if (pc_rinc && !will_scroll) begin
        cur_row_nxt = cur_row_r + RW'(1);
      end
    end else if (cmd_i.setcur) begin
      cur_col_nxt = sat_col_r;
      cur_row_nxt = sat_row_r;
    end else if (cmd_i.clear) begin
      cur_col_nxt = '0;
      cur_row_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_col_r <= '0;
      cur_row_r <= '0;
    end else begin
      cur_col_r <= cur_col_nxt;
      cur_row_r <= cur_row_nxt;
    end
  end

  // Cell address: cursor for writes, saturated coordinates for reads.
  wire logic [RW-1:0] a_row = cmd_i.rd ? sat_row_r : cur_row_r;
  wire logic [CW-1:0] a_col = cmd_i.rd ? sat_col_r : cur_col_r;
  wire logic [AW-1:0] cell_addr = AW'(AW'(a_row) * COLS_A + AW'(a_col));

  // Sweep unit: one cell a cycle, the write following the read in the next cycle.
  logic          sweep_act_r, sweep_copy_r, sweep_init_r;
  logic [AW-1:0] scan_r;
  logic          pend_valid_r, pend_copy_r;
  logic [AW-1:0] pend_addr_r;
  logic [15:0]   pend_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_act_r  <= 1'b1;
      sweep_copy_r <= 1'b0;
      sweep_init_r <= 1'b1;
      scan_r       <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      pend_valid_r <= sweep_act_r;
      if (cmd_i.sweep_start) begin
        sweep_act_r  <= 1'b1;
        sweep_copy_r <= cmd_i.sweep_copy;
        sweep_init_r <= 1'b0;
        scan_r       <= '0;
      end else if (sweep_act_r) begin
        if (scan_r == LAST_A) begin
          sweep_act_r <= 1'b0;
        end else begin
          scan_r <= scan_r + AW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= scan_r;
    pend_copy_r <= sweep_copy_r && (scan_r < COPY_LAST);
    pend_data_r <= sweep_init_r ? RESET_BLANK : blank;
  end

  // Screen memory.
  logic [15:0]   ram_rdata;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  wire  logic [AW-1:0] ram_raddr = cmd_i.rd ? cell_addr : AW'(scan_r + COLS_A);

  always_comb begin
    if (cmd_i.put) begin
      ram_we    = pc_write;
      ram_waddr = cell_addr;
      ram_wdata = {color, char_r};
    end else begin
      ram_we    = pend_valid_r;
      ram_waddr = pend_addr_r;
      ram_wdata = pend_copy_r ? ram_rdata : pend_data_r;
    end
  end

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result fields and output register.
  logic [15:0] res_data_r;
  logic        scrolled_r;
  logic        out_valid_r;

  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      res_data_r <= '0;
      scrolled_r <= 1'b0;
    end else begin
      if (cmd_i.rd_latch) begin
        res_data_r <= ram_rdata;
      end
      if (cmd_i.put && will_scroll) begin
        scrolled_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.load_out) begin
      out_tdata <= {3'b0, scrolled_r, 5'(cur_row_r), 7'(cur_col_r), res_data_r};
    end
  end

  assign out_tvalid        = out_valid_r;
  assign sts_o.kind        = kind_r;
  assign sts_o.will_scroll = will_scroll;
  assign sts_o.sweep_busy  = sweep_act_r | pend_valid_r;
  assign sts_o.out_free    = !out_valid_r || out_tready;

  // A character write never competes with a sweep write for the port.
  a_no_wr_clash: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.put |-> !sweep_act_r && !pend_valid_r)
    else $error("character write during a sweep");

  // The cursor stays on the screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (int'(cur_row_r) < ROWS) && (int'(cur_col_r) < COLUMNS))
    else $error("cursor left the screen");

  // A scroll parks the cursor on the last row and starts the row move.
  a_scroll_row: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_i.put && will_scroll) |=> (cur_row_r == ROW_LAST) && sweep_act_r && sweep_copy_r)
    else $error("scroll did not park cursor or start row move");

  // Only a read item returns cell data.
  a_data_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.capture |=> (res_data_r == '0) && !scrolled_r)
    else $error("stale result fields after capture");

endmodule
`default_nettype wire

>>> tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for text_console_writer_core
// Drives put character, set cursor, clear screen and read cell words into the
// console writer, predicts each result word from a shadow copy of the screen,
// cursor and colors, or takes it from the script, and compares field by field.
// ----------------------------------------------------------------------------
module testbench;
  import tcw_pkg::*;

  localparam int COLS         = DEF_COLUMNS;
  localparam int LINES        = DEF_ROWS;
  localparam int RANDOM_WORDS = 925;
  localparam int PHASES       = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int SCRIPT_LEN   = 25;

  // One result word, unpacked from out_tdata.
  typedef struct packed {
    logic [15:0] cell_val;
    logic [6:0]  ccol;
    logic [4:0]  crow;
    logic        scrolled;
  } console_res_t;

  // One row of the directed script. When typed is set, want holds the result
  // as read straight off the behavior; otherwise the shadow model decides.
  typedef struct packed {
    kind_t        kind;
    logic [7:0]   ch;
    logic [6:0]   col;
    logic [4:0]   row;
    logic         typed;
    console_res_t want;
  } script_row_t;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  // in_tdata: char_code [7:0], col [14:8], row [19:15], zero [23:20]
  logic [IN_TDATA_W-1:0]  in_tdata  = '0;
  // in_tuser: kind [1:0]
  logic [IN_TUSER_W-1:0]  in_tuser  = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // out_tdata: cell_data [15:0], cursor_col [22:16], cursor_row [27:23],
  //            scrolled [28], zero [31:29]
  logic [OUT_TDATA_W-1:0] out_tdata;

  text_console_writer_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow state of the console: screen cells, cursor and color registers.
  logic [15:0]  shadow_screen [COLS*LINES];
  int           shadow_col;
  int           shadow_row;
  logic [3:0]   fg_color;
  logic [3:0]   bg_color;

  console_res_t pending_results [$];

  int  err_count    = 0;
  int  n_words      = 0;
  int  n_results    = 0;
  int  n_scrolls    = 0;
  int  n_clears     = 0;
  int  n_color_sets = 0;

  // Coordination between the word source and the result sink.
  bit  no_gaps  = 1'b0;
  bit  steady   = 1'b0;
  bit  hold_req = 1'b0;

  // The directed part: reset contents, saturation at both edges, high
  // character bytes, tab, carriage return, wrap at the right edge, and
  // scrolls caused by a plain character, a tab and a newline on the last row.
  script_row_t script [SCRIPT_LEN] = '{
    '{KIND_READ,   8'h00,  7'd0,   5'd0,  1'b1, '{16'h0A20, 7'd0,  5'd0,  1'b0}},
    '{KIND_READ,   8'h00,  7'd127, 5'd31, 1'b1, '{16'h0A20, 7'd0,  5'd0,  1'b0}},
    '{KIND_PUT,    8'h41,  7'd0,   5'd0,  1'b0, '0},
    '{KIND_PUT,    8'hFF,  7'd127, 5'd31, 1'b0, '0},
    '{KIND_PUT,    8'h80,  7'd0,   5'd0,  1'b0, '0},
    '{KIND_PUT,    8'h00,  7'd0,   5'd0,  1'b0, '0},
    '{KIND_READ,   8'h00,  7'd0,   5'd0,  1'b1, '{16'h0A41, 7'd4,  5'd0,  1'b0}},
    '{KIND_READ,   8'h00,  7'd1,   5'd0,  1'b1, '{16'h0AFF, 7'd4,  5'd0,  1'b0}},
    '{KIND_PUT,    CH_TAB, 7'd0,   5'd0,  1'b0, '0},
    '{KIND_PUT,    CH_CR,  7'd0,   5'd0,  1'b0, '0},
    '{KIND_SETCUR, 8'h00,  7'd127, 5'd31, 1'b1, '{16'h0000, 7'd79, 5'd24, 1'b0}},
    '{KIND_PUT,    8'h5A,  7'd0,   5'd0,  1'b1, '{16'h0000, 7'd0,  5'd24, 1'b1}},
    '{KIND_READ,   8'h00,  7'd79,  5'd23, 1'b1, '{16'h0A5A, 7'd0,  5'd24, 1'b0}},
    '{KIND_SETCUR, 8'h00,  7'd76,  5'd10, 1'b0, '0},
    '{KIND_PUT,    CH_TAB, 7'd0,   5'd0,  1'b0, '0},
    '{KIND_SETCUR, 8'h00,  7'd79,  5'd24, 1'b0, '0},
    '{KIND_PUT,    CH_TAB, 7'd0,   5'd0,  1'b1, '{16'h0000, 7'd0,  5'd24, 1'b1}},
    '{KIND_PUT,    CH_LF,  7'd0,   5'd0,  1'b1, '{16'h0000, 7'd0,  5'd24, 1'b1}},
    '{KIND_SETCUR, 8'h00,  7'd80,  5'd25, 1'b1, '{16'h0000, 7'd79, 5'd24, 1'b0}},
    '{KIND_CLEAR,  8'h00,  7'd0,   5'd0,  1'b1, '{16'h0000, 7'd0,  5'd0,  1'b0}},
    '{KIND_PUT,    CH_LF,  7'd0,   5'd0,  1'b0, '0},
    '{KIND_READ,   8'h00,  7'd40,  5'd12, 1'b1, '{16'h0A20, 7'd0,  5'd1,  1'b0}},
    '{KIND_SETCUR, 8'h00,  7'd3,   5'd5,  1'b0, '0},
    '{KIND_PUT,    CH_CR,  7'd0,   5'd0,  1'b0, '0},
    '{KIND_PUT,    8'h7F,  7'd0,   5'd0,  1'b0, '0}
  };

  function automatic int clamp(int v, int lim);
    return (v >= lim) ? lim - 1 : v;
  endfunction

  // Applies one accepted word to the shadow console and returns the result
  // word that the block must produce for it.
  function automatic console_res_t console_step(kind_t k, logic [7:0] ch,
                                                logic [6:0] c, logic [4:0] r);
    console_res_t res;
    res = '0;
    case (k)
      KIND_PUT: begin
        if (ch == CH_LF) begin
          shadow_col = 0;
          shadow_row++;
        end else if (ch == CH_CR) begin
          shadow_col = 0;
        end else if (ch == CH_TAB) begin
          shadow_col = (shadow_col + TAB_STEP) & ~(TAB_STEP - 1);
        end else begin
          shadow_screen[shadow_row*COLS + shadow_col] = {bg_color, fg_color, ch};
          shadow_col++;
        end
        if (shadow_col >= COLS) begin
          shadow_col = 0;
          shadow_row++;
        end
        // Running off the bottom moves every line up one and blanks the last.
        if (shadow_row >= LINES) begin
          for (int i = 0; i < (LINES-1)*COLS; i++)
            shadow_screen[i] = shadow_screen[i+COLS];
          for (int i = (LINES-1)*COLS; i < LINES*COLS; i++)
            shadow_screen[i] = {bg_color, fg_color, BLANK_CHAR};
          shadow_row = LINES - 1;
          res.scrolled = 1'b1;
          n_scrolls++;
        end
      end
      KIND_SETCUR: begin
        shadow_col = clamp(c, COLS);
        shadow_row = clamp(r, LINES);
      end
      KIND_CLEAR: begin
        foreach (shadow_screen[i])
          shadow_screen[i] = {bg_color, fg_color, BLANK_CHAR};
        shadow_col = 0;
        shadow_row = 0;
        n_clears++;
      end
      default: begin
        res.cell_val = shadow_screen[clamp(r, LINES)*COLS + clamp(c, COLS)];
      end
    endcase
    res.ccol = 7'(shadow_col);
    res.crow = 5'(shadow_row);
    return res;
  endfunction

  // Idle time between words: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps) return 0;
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int pick_stall();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // Characters lean toward printable text, with enough control characters
  // to wrap, tab and scroll often, and some arbitrary bytes.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 8'($urandom_range(8'h20, 8'h7E));
    if (r < 73) return CH_LF;
    if (r < 78) return CH_CR;
    if (r < 85) return CH_TAB;
    return 8'($urandom);
  endfunction

  function automatic logic [6:0] pick_col();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 7'($urandom_range(0, COLS - 1));
    if (r < 85) return 7'($urandom_range(COLS - 8, COLS - 1));
    return 7'($urandom);
  endfunction

  function automatic logic [4:0] pick_row();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 5'($urandom_range(0, LINES - 1));
    if (r < 85) return 5'($urandom_range(LINES - 5, LINES - 1));
    return 5'($urandom);
  endfunction

  // Offers one word, waits for the handshake, records the expected result.
  // A gap of zero leaves in_tvalid high so that the next word follows at once.
  task automatic send_word(input kind_t k, input logic [7:0] ch,
                           input logic [6:0] c, input logic [4:0] r,
                           input logic typed, input console_res_t want);
    console_res_t res;
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= k;
    in_tdata  <= {4'b0, r, c, ch};
    do @(posedge clk); while (!in_tready);
    res = console_step(k, ch, c, r);
    pending_results.push_back(typed ? want : res);
    n_words++;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Stops offering words and lets every outstanding result arrive. Each word
  // gives exactly one result, so an empty queue means the block is idle; the
  // few extra cycles catch any stray word.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_colors(input logic [3:0] fg, input logic [3:0] bg);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FG;
    cfg_data  <= fg;
    @(posedge clk);
    fg_color = fg;
    cfg_index <= REG_BG;
    cfg_data  <= bg;
    @(posedge clk);
    bg_color = bg;
    cfg_we <= 1'b0;
    n_color_sets++;
  endtask

  // One random episode. Text runs dominate: they move the cursor somewhere,
  // often near the right edge or the bottom, write a burst of characters and
  // frequently read back the cell just written. The rest are plain reads,
  // cursor moves, clears and fully random words.
  task automatic run_episode();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      if ($urandom_range(0, 1) == 1)
        send_word(KIND_SETCUR, 8'($urandom), pick_col(), pick_row(), 1'b0, '0);
      repeat ($urandom_range(1, 16))
        send_word(KIND_PUT, pick_char(), 7'($urandom), 5'($urandom), 1'b0, '0);
      if ($urandom_range(0, 99) < 40)
        send_word(KIND_READ, 8'($urandom),
                  7'((shadow_col > 0) ? shadow_col - 1 : COLS - 1), 5'(shadow_row),
                  1'b0, '0);
    end else if (sel < 75) begin
      repeat ($urandom_range(1, 4))
        send_word(KIND_READ, 8'($urandom), 7'($urandom), 5'($urandom), 1'b0, '0);
    end else if (sel < 85) begin
      send_word(KIND_SETCUR, 8'($urandom), 7'($urandom), 5'($urandom), 1'b0, '0);
    end else if (sel < 88) begin
      send_word(KIND_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom), 1'b0, '0);
    end else begin
      send_word(kind_t'($urandom_range(0, 3)), 8'($urandom), 7'($urandom),
                5'($urandom), 1'b0, '0);
    end
  endtask

  // Word source: reset, directed script, then random phases, each under its
  // own color setting.
  initial begin : word_source
    int phase_start;
    foreach (shadow_screen[i]) shadow_screen[i] = RESET_BLANK;
    shadow_col = 0;
    shadow_row = 0;
    fg_color = RESET_FG;
    bg_color = RESET_BG;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    // The clearing pass after reset holds in_tready low; the handshake in
    // send_word simply waits it out.
    for (int i = 0; i < SCRIPT_LEN; i++)
      send_word(script[i].kind, script[i].ch, script[i].col, script[i].row,
                script[i].typed, script[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0:       set_colors(4'hF, 4'hF);
        1:       set_colors(4'h0, 4'h0);
        default: set_colors(4'($urandom), 4'($urandom));
      endcase
      // Phase 2 floods the block while the sink holds off, so the block
      // fills up and stalls its input. Phase 3 runs with no idling at all.
      no_gaps = (ph == 2) || (ph == 3);
      steady  = (ph == 3);
      if (ph == 2) hold_req = 1'b1;
      phase_start = n_words;
      while (n_words - phase_start < RANDOM_WORDS / PHASES)
        run_episode();
    end

    wait_drained();
    repeat (20) @(posedge clk);
    $display("Sent %0d words (%0d directed) under %0d color settings; checked %0d results.",
             n_words, SCRIPT_LEN, n_color_sets, n_results);
    $display("Screen activity: %0d scrolls and %0d clears.", n_scrolls, n_clears);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Result sink: random ready pattern with mostly short stalls, a long
  // hold-off when asked for one, and no stalls at all while steady is set.
  initial begin : result_sink
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (steady) begin
        out_tready <= 1'b1;
        @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_tready <= 1'b0;
        repeat (pick_stall()) @(posedge clk);
      end
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // Every accepted result word is matched against the oldest expectation.
  always @(posedge clk) begin : result_check
    console_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t: result word %h arrived with nothing expected", $time, out_tdata);
      end else begin
        want = pending_results.pop_front();
        n_results++;
        check_field("cell_data",  want.cell_val, out_tdata[15:0]);
        check_field("cursor_col", want.ccol,     out_tdata[22:16]);
        check_field("cursor_row", want.crow,     out_tdata[27:23]);
        check_field("scrolled",   want.scrolled, out_tdata[28]);
      end
    end
  end

  // Watchdog: far beyond any correct run, even one where every word scrolls.
  initial begin : watchdog
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

>>> files.f
hdl/tcw_pkg.sv
hdl/tcw_ram.sv
hdl/tcw_ctrl.sv
hdl/tcw_dp.sv
hdl/text_console_writer_core.sv
tb/sv/testbench.sv
